>>> src/bcrd_pkg.sv
package bcrd_pkg;

	// Fixed-point format of the datapath.
	localparam int FRACTION_BITS = 14;

	// Field and datapath widths.
	localparam int WORD_W   = 32;
	localparam int CFG_W    = 64;
	localparam int IDX_W    = 2;
	localparam int FS_W     = 16;
	localparam int CH_W     = 16;
	localparam int ENTRY_W  = 8;
	localparam int A_W      = FRACTION_BITS + 1;
	localparam int DIFF_W   = FRACTION_BITS;
	localparam int Y_W      = FRACTION_BITS + 2;
	localparam int K_W      = FRACTION_BITS + 1;
	localparam int PROD_W   = K_W + 1 + ENTRY_W;
	localparam int SUM_W    = 2 * FRACTION_BITS + 4;
	localparam int CLAMP_W  = 2 * FRACTION_BITS + 1;
	localparam int MUL_W    = CLAMP_W + FS_W;
	localparam int N_PIX    = 4;
	localparam int N_CH     = 3 * N_PIX;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_CHROMA_LOW  = 2'd0,
		REG_CHROMA_HIGH = 2'd1,
		REG_FULL_SCALE  = 2'd2
	} reg_index_t;

	localparam logic [FS_W-1:0] FULL_SCALE_RESET = FS_W'(255);

	// Color conversion coefficients, rounded half up to the fraction width.
	localparam longint K_1402 = ((longint'(1402) << FRACTION_BITS) + 500) / 1000;
	localparam longint K_0344 = ((longint'(344136) << FRACTION_BITS) + 500000) / 1000000;
	localparam longint K_0714 = ((longint'(714136) << FRACTION_BITS) + 500000) / 1000000;
	localparam longint K_1772 = ((longint'(1772) << FRACTION_BITS) + 500) / 1000;

	localparam logic signed [K_W:0] K_1402_S = (K_W + 1)'(K_1402);
	localparam logic signed [K_W:0] K_0344_S = (K_W + 1)'(K_0344);
	localparam logic signed [K_W:0] K_0714_S = (K_W + 1)'(K_0714);
	localparam logic signed [K_W:0] K_1772_S = (K_W + 1)'(K_1772);

	// A clamped value of one, with twice the fraction bits.
	localparam longint TOP_2F = longint'(1) << (2 * FRACTION_BITS);

	typedef logic [A_W-1:0] a_tab_t [64];
	typedef logic signed [DIFF_W-1:0] diff_tab_t [64];

	// Luma average a scaled by 1/63, rounded half up.
	function automatic a_tab_t build_a_tab();
		a_tab_t t;
		for (int i = 0; i < 64; i++) begin
			t[i] = A_W'(((longint'(i) << FRACTION_BITS) + 31) / 63);
		end
		return t;
	endfunction

	// Signed 6-bit difference scaled by 0.3/31, halves away from zero.
	function automatic diff_tab_t build_diff_tab();
		diff_tab_t t;
		longint v;
		longint mag;
		longint q;
		for (int i = 0; i < 64; i++) begin
			v   = (i >= 32) ? longint'(i) - 64 : longint'(i);
			mag = (v < 0) ? -v : v;
			q   = (((mag * 3) << FRACTION_BITS) + 155) / 310;
			t[i] = DIFF_W'((v < 0) ? -q : q);
		end
		return t;
	endfunction

	localparam a_tab_t    A_TAB    = build_a_tab();
	localparam diff_tab_t DIFF_TAB = build_diff_tab();

endpackage

>>> src/bcrd_cw_if.sv
interface bcrd_cw_if;
	logic                        valid;
	logic                        ready;
	logic [bcrd_pkg::WORD_W-1:0] codeword;

	modport source (output valid, output codeword, input ready);
	modport sink (input valid, input codeword, output ready);
endinterface

>>> src/bcrd_rgb_if.sv
interface bcrd_rgb_if;
	logic                      valid;
	logic                      ready;
	logic [bcrd_pkg::CH_W-1:0] top_left_red;
	logic [bcrd_pkg::CH_W-1:0] top_left_green;
	logic [bcrd_pkg::CH_W-1:0] top_left_blue;
	logic [bcrd_pkg::CH_W-1:0] top_right_red;
	logic [bcrd_pkg::CH_W-1:0] top_right_green;
	logic [bcrd_pkg::CH_W-1:0] top_right_blue;
	logic [bcrd_pkg::CH_W-1:0] bottom_left_red;
	logic [bcrd_pkg::CH_W-1:0] bottom_left_green;
	logic [bcrd_pkg::CH_W-1:0] bottom_left_blue;
	logic [bcrd_pkg::CH_W-1:0] bottom_right_red;
	logic [bcrd_pkg::CH_W-1:0] bottom_right_green;
	logic [bcrd_pkg::CH_W-1:0] bottom_right_blue;

	modport source (
		output valid,
		output top_left_red, output top_left_green, output top_left_blue,
		output top_right_red, output top_right_green, output top_right_blue,
		output bottom_left_red, output bottom_left_green, output bottom_left_blue,
		output bottom_right_red, output bottom_right_green, output bottom_right_blue,
		input  ready
	);
	modport sink (
		input  valid,
		input  top_left_red, input top_left_green, input top_left_blue,
		input  top_right_red, input top_right_green, input top_right_blue,
		input  bottom_left_red, input bottom_left_green, input bottom_left_blue,
		input  bottom_right_red, input bottom_right_green, input bottom_right_blue,
		output ready
	);
endinterface

>>> src/block_codeword_to_rgb_decoder.sv
// Decodes one 32-bit codeword per clock into the twelve 16-bit RGB samples of a 2x2 pixel
// block. The path is four register stages deep: field lookup, luma transform and chroma
// products, YPbPr to RGB sum and clamp, scaling by full_scale. A new word is taken every
// cycle as long as the pixel channel takes its beats; when it stalls, the whole pipeline
// holds. The chroma table and full_scale must be written through the register port only
// while the block is idle; the block itself does not enforce this. After reset the chroma
// table reads zero and full_scale is 255.
module block_codeword_to_rgb_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [bcrd_pkg::IDX_W-1:0]    wr_index,
	input  logic [bcrd_pkg::CFG_W-1:0]    wr_data,
	bcrd_cw_if.sink                       codeword_bus,
	bcrd_rgb_if.source                    pixel_bus
);

	// Configuration registers.
	logic [bcrd_pkg::CFG_W-1:0] chroma_low_q;
	logic [bcrd_pkg::CFG_W-1:0] chroma_high_q;
	logic [bcrd_pkg::FS_W-1:0]  full_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chroma_low_q  <= '0;
			chroma_high_q <= '0;
			full_scale_q  <= bcrd_pkg::FULL_SCALE_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				bcrd_pkg::REG_CHROMA_LOW:  chroma_low_q  <= wr_data;
				bcrd_pkg::REG_CHROMA_HIGH: chroma_high_q <= wr_data;
				bcrd_pkg::REG_FULL_SCALE:  full_scale_q  <= wr_data[bcrd_pkg::FS_W-1:0];
				default: ;
			endcase
		end
	end

	// Picks one signed byte of the chroma table.
	function automatic logic signed [bcrd_pkg::ENTRY_W-1:0] chroma_entry(
		input logic [3:0]                 idx,
		input logic [bcrd_pkg::CFG_W-1:0] lo,
		input logic [bcrd_pkg::CFG_W-1:0] hi
	);
		logic [bcrd_pkg::CFG_W-1:0] word;
		word = idx[3] ? hi : lo;
		return $signed(word[{idx[2:0], 3'b000} +: bcrd_pkg::ENTRY_W]);
	endfunction

	// Limits a sum to the range zero to one.
	function automatic logic [bcrd_pkg::CLAMP_W-1:0] clamp(
		input logic signed [bcrd_pkg::SUM_W-1:0] s
	);
		logic [bcrd_pkg::CLAMP_W-1:0] r;
		if (s < 0) begin
			r = '0;
		end else if (s > bcrd_pkg::SUM_W'(bcrd_pkg::TOP_2F)) begin
			r = bcrd_pkg::CLAMP_W'(bcrd_pkg::TOP_2F);
		end else begin
			r = bcrd_pkg::CLAMP_W'(s);
		end
		return r;
	endfunction

	// The whole pipeline moves unless a finished beat waits at the output.
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;

	assign adv                = !v_s4 || pixel_bus.ready;
	assign codeword_bus.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= codeword_bus.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: unpack the word, scale the luma fields and look up chroma.
	logic        [bcrd_pkg::A_W-1:0]     a_s1;
	logic signed [bcrd_pkg::DIFF_W-1:0]  b_s1, c_s1, d_s1;
	logic signed [bcrd_pkg::ENTRY_W-1:0] pb_s1, pr_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1  <= bcrd_pkg::A_TAB[codeword_bus.codeword[31:26]];
			b_s1  <= bcrd_pkg::DIFF_TAB[codeword_bus.codeword[25:20]];
			c_s1  <= bcrd_pkg::DIFF_TAB[codeword_bus.codeword[19:14]];
			d_s1  <= bcrd_pkg::DIFF_TAB[codeword_bus.codeword[13:8]];
			pb_s1 <= chroma_entry(codeword_bus.codeword[7:4], chroma_low_q, chroma_high_q);
			pr_s1 <= chroma_entry(codeword_bus.codeword[3:0], chroma_low_q, chroma_high_q);
		end
	end

	// Stage 2: inverse transform to four luma values, and the four chroma products.
	logic signed [bcrd_pkg::Y_W-1:0]    ya;
	logic signed [bcrd_pkg::Y_W-1:0]    yb, yc, yd;
	logic signed [bcrd_pkg::Y_W-1:0]    y_s2 [bcrd_pkg::N_PIX];
	logic signed [bcrd_pkg::PROD_W-1:0] kr_pr_s2, kg_pb_s2, kg_pr_s2, kb_pb_s2;

	assign ya = $signed({1'b0, a_s1});
	assign yb = bcrd_pkg::Y_W'(b_s1);
	assign yc = bcrd_pkg::Y_W'(c_s1);
	assign yd = bcrd_pkg::Y_W'(d_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s2[0]  <= ya - yb - yc + yd;
			y_s2[1]  <= ya - yb + yc - yd;
			y_s2[2]  <= ya + yb - yc - yd;
			y_s2[3]  <= ya + yb + yc + yd;
			kr_pr_s2 <= bcrd_pkg::K_1402_S * pr_s1;
			kg_pb_s2 <= bcrd_pkg::K_0344_S * pb_s1;
			kg_pr_s2 <= bcrd_pkg::K_0714_S * pr_s1;
			kb_pb_s2 <= bcrd_pkg::K_1772_S * pb_s1;
		end
	end

	// Stage 3: YPbPr to RGB with twice the fraction bits, then clamp.
	logic signed [bcrd_pkg::SUM_W-1:0]   kr_sh, kgb_sh, kgr_sh, kb_sh;
	logic signed [bcrd_pkg::SUM_W-1:0]   ys   [bcrd_pkg::N_PIX];
	logic        [bcrd_pkg::CLAMP_W-1:0] clamp_d [bcrd_pkg::N_CH];
	logic        [bcrd_pkg::CLAMP_W-1:0] clamp_s3 [bcrd_pkg::N_CH];

	assign kr_sh  = bcrd_pkg::SUM_W'(kr_pr_s2) <<< (bcrd_pkg::FRACTION_BITS - 8);
	assign kgb_sh = bcrd_pkg::SUM_W'(kg_pb_s2) <<< (bcrd_pkg::FRACTION_BITS - 8);
	assign kgr_sh = bcrd_pkg::SUM_W'(kg_pr_s2) <<< (bcrd_pkg::FRACTION_BITS - 8);
	assign kb_sh  = bcrd_pkg::SUM_W'(kb_pb_s2) <<< (bcrd_pkg::FRACTION_BITS - 8);

	always_comb begin
		for (int k = 0; k < bcrd_pkg::N_PIX; k++) begin
			ys[k]            = bcrd_pkg::SUM_W'(y_s2[k]) <<< bcrd_pkg::FRACTION_BITS;
			clamp_d[3*k]     = clamp(ys[k] + kr_sh);
			clamp_d[3*k + 1] = clamp(ys[k] - kgb_sh - kgr_sh);
			clamp_d[3*k + 2] = clamp(ys[k] + kb_sh);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			clamp_s3 <= clamp_d;
		end
	end

	// Stage 4: scale each channel by full_scale and drop the fraction bits.
	logic [bcrd_pkg::MUL_W-1:0] mul_d [bcrd_pkg::N_CH];
	logic [bcrd_pkg::CH_W-1:0]  out_s4 [bcrd_pkg::N_CH];

	always_comb begin
		for (int k = 0; k < bcrd_pkg::N_CH; k++) begin
			mul_d[k] = bcrd_pkg::MUL_W'(clamp_s3[k]) * bcrd_pkg::MUL_W'(full_scale_q);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < bcrd_pkg::N_CH; k++) begin
				out_s4[k] <= mul_d[k][2*bcrd_pkg::FRACTION_BITS +: bcrd_pkg::CH_W];
			end
		end
	end

	assign pixel_bus.valid              = v_s4;
	assign pixel_bus.top_left_red       = out_s4[0];
	assign pixel_bus.top_left_green     = out_s4[1];
	assign pixel_bus.top_left_blue      = out_s4[2];
	assign pixel_bus.top_right_red      = out_s4[3];
	assign pixel_bus.top_right_green    = out_s4[4];
	assign pixel_bus.top_right_blue     = out_s4[5];
	assign pixel_bus.bottom_left_red    = out_s4[6];
	assign pixel_bus.bottom_left_green  = out_s4[7];
	assign pixel_bus.bottom_left_blue   = out_s4[8];
	assign pixel_bus.bottom_right_red   = out_s4[9];
	assign pixel_bus.bottom_right_green = out_s4[10];
	assign pixel_bus.bottom_right_blue  = out_s4[11];

	// A word in the first stage moves on when the pipeline advances.
	assert property (@(posedge clk) disable iff (!arst_n) adv && v_s1 |=> v_s2)
		else $error("stage 1 word lost while advancing");

	// A stalled word in the second stage keeps its first and last luma values.
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv && v_s2 |=> v_s2 && $stable(y_s2[0]) && $stable(y_s2[3]))
		else $error("stage 2 changed during a stall");

	// The first and last clamped channels of a valid stage 3 word never exceed one.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> clamp_s3[0] <= bcrd_pkg::CLAMP_W'(bcrd_pkg::TOP_2F)
			&& clamp_s3[11] <= bcrd_pkg::CLAMP_W'(bcrd_pkg::TOP_2F))
		else $error("clamped channel above one");

endmodule
